@@ sv/wmvm_pkg.sv @@
// ----------------------------------------------------------------------------
// Weight matrix vector multiply package
// Shared constants, configuration register indexes and the command and
// status types that join the controller to the datapath.
// ----------------------------------------------------------------------------
package wmvm_pkg;

  localparam int MAX_DIM    = 64;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int CNT_W      = IDX_W + 1;
  localparam int WADDR_W    = 2 * IDX_W;
  localparam int VALUE_W    = 16;
  localparam int PROD_W     = 2 * VALUE_W;
  localparam int ACC_W      = 38;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_VECTOR = 1'b1;

  typedef struct packed {
    logic               wr_weight;
    logic               wr_vec;
    logic [IDX_W-1:0]   vec_waddr;
    logic               rd;
    logic               first;
    logic [WADDR_W-1:0] rd_waddr;
    logic [IDX_W-1:0]   rd_vaddr;
    logic               emit;
    logic               emit_err;
    logic               emit_last;
    logic [IDX_W-1:0]   emit_index;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] d);
    logic [CNT_W-1:0] r;
    if (d == '0) begin
      r = CNT_W'(1);
    end else if (CNT_W'(d) > CNT_W'(MAX_DIM)) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(d);
    end
    return r;
  endfunction

endpackage

@@ sv/weight_matrix_vector_multiply.sv @@
// Weight write and vector element items are taken only while no multiply runs.
// A last element starts the multiply, or a size error item when the count
// of elements is not the input dimension. Each result row does one weight
// and vector read per cycle, then the multiply and accumulate stages drain.
// Reset is synchronous and active low; it clears the control state and sets
// both dimensions to 64, while the weight and vector memories are not cleared.
// ----------------------------------------------------------------------------
// Weight matrix vector multiply
// Stores a weight matrix and a vector, and streams out the product of the
// matrix, or its transpose, with the vector as one item per output row.
// ----------------------------------------------------------------------------
module weight_matrix_vector_multiply (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [wmvm_pkg::IDX_W-1:0]           in_row_index,
  input  logic [wmvm_pkg::IDX_W-1:0]           in_col_index,
  input  logic signed [wmvm_pkg::VALUE_W-1:0]  in_weight_value,
  input  logic signed [wmvm_pkg::VALUE_W-1:0]  in_vector_value,
  input  logic                                 in_transpose,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wmvm_pkg::IDX_W-1:0]           out_result_index,
  output logic signed [wmvm_pkg::ACC_W-1:0]    out_result_value,
  output logic                                 out_result_last,
  output logic                                 out_size_error,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wmvm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wmvm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  wmvm_pkg::cmd_t  cmd;
  wmvm_pkg::stat_t stat;

  wmvm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_transpose (in_transpose),
    .in_last      (in_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .stat         (stat),
    .cmd          (cmd)
  );

  wmvm_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_weight_value  (in_weight_value),
    .in_vector_value  (in_vector_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_index (out_result_index),
    .out_result_value (out_result_value),
    .out_result_last  (out_result_last),
    .out_size_error   (out_size_error)
  );

endmodule

@@ sv/wmvm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Weight matrix vector multiply controller
// Holds the dimension registers and the element count, accepts items and
// sequences the row and column loops of the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module wmvm_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic                                in_transpose,
  input  logic                                in_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wmvm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wmvm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wmvm_pkg::stat_t                     stat,
  output wmvm_pkg::cmd_t                      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT,
    S_ERR
  } state_t;

  state_t                              state_r, state_nxt;
  logic [wmvm_pkg::IDX_W-1:0]          i_r, i_nxt;
  logic [wmvm_pkg::IDX_W-1:0]          j_r, j_nxt;
  logic [wmvm_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [wmvm_pkg::CNT_W-1:0]          nin_r, nin_nxt;
  logic [wmvm_pkg::CNT_W-1:0]          nout_r, nout_nxt;
  logic                                trans_r, trans_nxt;
  logic                                drain_r, drain_nxt;
  logic [wmvm_pkg::CFG_DATA_W-1:0]     rows_r, cols_r;

  logic                                in_acc;
  logic [wmvm_pkg::CNT_W-1:0]          cnt_inc;
  logic [wmvm_pkg::CNT_W-1:0]          rows_c, cols_c, nin_c, nout_c;
  logic                                j_end, i_end;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign rows_c    = wmvm_pkg::clamp_dim(rows_r);
  assign cols_c    = wmvm_pkg::clamp_dim(cols_r);
  assign nin_c     = in_transpose ? rows_c : cols_c;
  assign nout_c    = in_transpose ? cols_c : rows_c;
  assign cnt_inc   = (cnt_r <= wmvm_pkg::CNT_W'(wmvm_pkg::MAX_DIM)) ?
                     cnt_r + wmvm_pkg::CNT_W'(1) : cnt_r;
  assign j_end     = ({1'b0, j_r} == nin_r - wmvm_pkg::CNT_W'(1));
  assign i_end     = ({1'b0, i_r} == nout_r - wmvm_pkg::CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    nin_nxt   = nin_r;
    nout_nxt  = nout_r;
    trans_nxt = trans_r;
    drain_nxt = drain_r;
    cmd       = '0;
    cmd.vec_waddr  = cnt_r[wmvm_pkg::IDX_W-1:0];
    cmd.rd_waddr   = trans_r ? {j_r, i_r} : {i_r, j_r};
    cmd.rd_vaddr   = j_r;
    cmd.first      = (j_r == '0);
    cmd.emit_index = i_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind == wmvm_pkg::KIND_WEIGHT) begin
            cmd.wr_weight = 1'b1;
          end else begin
            cmd.wr_vec = (cnt_r < wmvm_pkg::CNT_W'(wmvm_pkg::MAX_DIM));
            cnt_nxt    = cnt_inc;
            if (in_last) begin
              cnt_nxt   = '0;
              nin_nxt   = nin_c;
              nout_nxt  = nout_c;
              trans_nxt = in_transpose;
              i_nxt     = '0;
              j_nxt     = '0;
              state_nxt = (cnt_inc != nin_c) ? S_ERR : S_RUN;
            end
          end
        end
      end
      S_RUN: begin
        cmd.rd = 1'b1;
        if (j_end) begin
          drain_nxt = 1'b0;
          state_nxt = S_DRAIN;
        end else begin
          j_nxt = j_r + wmvm_pkg::IDX_W'(1);
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = i_end;
          j_nxt         = '0;
          if (i_end) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + wmvm_pkg::IDX_W'(1);
            state_nxt = S_RUN;
          end
        end
      end
      S_ERR: begin
        cmd.emit_index = '0;
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_err  = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
      nin_r   <= wmvm_pkg::CNT_W'(1);
      nout_r  <= wmvm_pkg::CNT_W'(1);
      trans_r <= 1'b0;
      drain_r <= 1'b0;
      rows_r  <= wmvm_pkg::CFG_DATA_W'(wmvm_pkg::MAX_DIM);
      cols_r  <= wmvm_pkg::CFG_DATA_W'(wmvm_pkg::MAX_DIM);
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
      nin_r   <= nin_nxt;
      nout_r  <= nout_nxt;
      trans_r <= trans_nxt;
      drain_r <= drain_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == wmvm_pkg::REG_NUM_ROWS) begin
          rows_r <= cfg_data;
        end else if (cfg_index == wmvm_pkg::REG_NUM_COLS) begin
          cols_r <= cfg_data;
        end
      end
    end
  end

endmodule

@@ sv/wmvm_datapath.sv @@
// ----------------------------------------------------------------------------
// Weight matrix vector multiply datapath
// Weight and vector memories, a pipelined multiply-accumulate unit and the
// result register that holds one item until the consumer takes it.
// ----------------------------------------------------------------------------
module wmvm_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  wmvm_pkg::cmd_t                       cmd,
  output wmvm_pkg::stat_t                      stat,
  input  logic [wmvm_pkg::IDX_W-1:0]           in_row_index,
  input  logic [wmvm_pkg::IDX_W-1:0]           in_col_index,
  input  logic signed [wmvm_pkg::VALUE_W-1:0]  in_weight_value,
  input  logic signed [wmvm_pkg::VALUE_W-1:0]  in_vector_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wmvm_pkg::IDX_W-1:0]           out_result_index,
  output logic signed [wmvm_pkg::ACC_W-1:0]    out_result_value,
  output logic                                 out_result_last,
  output logic                                 out_size_error
);

  logic [wmvm_pkg::VALUE_W-1:0] wmem [wmvm_pkg::MAX_DIM * wmvm_pkg::MAX_DIM];
  logic [wmvm_pkg::VALUE_W-1:0] vmem [wmvm_pkg::MAX_DIM];

  logic [wmvm_pkg::VALUE_W-1:0]        w_q_r, v_q_r;
  logic                                v1_r, first1_r;
  logic signed [wmvm_pkg::PROD_W-1:0]  prod_r;
  logic                                v2_r, first2_r;
  logic signed [wmvm_pkg::ACC_W-1:0]   acc_r;
  logic signed [wmvm_pkg::ACC_W-1:0]   prod_ext;

  logic                                out_valid_r;
  logic [wmvm_pkg::IDX_W-1:0]          out_index_r;
  logic signed [wmvm_pkg::ACC_W-1:0]   out_value_r;
  logic                                out_last_r;
  logic                                out_err_r;

  assign prod_ext      = wmvm_pkg::ACC_W'(prod_r);
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr_weight) begin
      wmem[{in_row_index, in_col_index}] <= in_weight_value;
    end
    if (cmd.wr_vec) begin
      vmem[cmd.vec_waddr] <= in_vector_value;
    end
    if (cmd.rd) begin
      w_q_r <= wmem[cmd.rd_waddr];
      v_q_r <= vmem[cmd.rd_vaddr];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(w_q_r) * $signed(v_q_r);
    if (v2_r) begin
      acc_r <= first2_r ? prod_ext : acc_r + prod_ext;
    end
    if (cmd.emit) begin
      out_index_r <= cmd.emit_index;
      out_value_r <= cmd.emit_err ? '0 : acc_r;
      out_last_r  <= cmd.emit_last;
      out_err_r   <= cmd.emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      first1_r    <= 1'b0;
      v2_r        <= 1'b0;
      first2_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r     <= cmd.rd;
      first1_r <= cmd.first;
      v2_r     <= v1_r;
      first2_r <= first1_r;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_result_value = out_value_r;
  assign out_result_last  = out_last_r;
  assign out_size_error   = out_err_r;

endmodule

@@ sv/wmvm_checker.sv @@
// ----------------------------------------------------------------------------
// Weight matrix vector multiply port checker
// Watches the top-level ports; flags result items that break the handshake,
// carry an inconsistent error report or follow reset, and mid-stream input.
// ----------------------------------------------------------------------------
module wmvm_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [wmvm_pkg::IDX_W-1:0]           out_result_index,
  input logic signed [wmvm_pkg::ACC_W-1:0]    out_result_value,
  input logic                                 out_result_last,
  input logic                                 out_size_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result item withdrawn before it was taken.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result_value) && $stable(out_result_index)
      && $stable(out_result_last) && $stable(out_size_error))
    else $error("Result item changed while stalled.");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_size_error |-> out_result_last && out_result_index == '0
      && out_result_value == '0)
    else $error("Size error item is not a single final zero result.");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("Result item shown straight after reset.");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_last |-> !(in_valid && in_ready))
    else $error("Item taken while a multiply is still streaming results.");

endmodule

bind weight_matrix_vector_multiply wmvm_checker u_wmvm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_index (out_result_index),
  .out_result_value (out_result_value),
  .out_result_last  (out_result_last),
  .out_size_error   (out_size_error)
);
